// ----- rtl/tilt_pkg.sv -----
// tilt_pkg: shared widths, register indexes, constants and the cordic angle table
// for the tilt angle alarm. No dependencies.

package tilt_pkg;

   // field widths
   localparam int ACCEL_W     = 16;
   localparam int ROLL_W      = 8;
   localparam int PITCH_W     = 9;
   localparam int ANGLE_W     = 9;   // signed angle, -180..180
   localparam int PITCH_EXT_W = 10;  // signed pitch after offset, -13..347
   localparam int ROUND_W     = 7;   // first quadrant angle, 0..90
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROLL_DANGER   = 2'd0,
      CSR_PITCH_DANGER  = 2'd1,
      CSR_ROLL_WARNING  = 2'd2,
      CSR_PITCH_WARNING = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [ROLL_W-1:0]  ROLL_DANGER_RST   = 8'd20;
   localparam logic [PITCH_W-1:0] PITCH_DANGER_RST  = 9'd25;
   localparam logic [ROLL_W-1:0]  ROLL_WARNING_RST  = 8'd15;
   localparam logic [PITCH_W-1:0] PITCH_WARNING_RST = 9'd20;

   // angle constants
   localparam int PRE_SHIFT        = 16;
   localparam int RIGHT_ANGLE      = 90;
   localparam int HALF_TURN        = 180;
   localparam int FULL_TURN        = 360;
   localparam int PITCH_OFFSET     = 167;
   localparam int PITCH_FOLD_LIMIT = 300;

   // sign and zero flags of the operands, carried down the cordic pipe
   typedef struct packed {
      logic num_neg;
      logic den_neg;
      logic num_zero;
   } quad_type;

   // atan(2^-i) in nanodegrees
   localparam int ATAN_TABLE_LEN = 24;
   localparam logic [63:0] NANODEG_PER_DEG = 64'd1000000000;
   localparam logic [63:0] ATAN_NANODEG [ATAN_TABLE_LEN] = '{
      64'd45000000000, 64'd26565051177, 64'd14036243467, 64'd7125016349,
      64'd3576334375,  64'd1789910608,  64'd895173710,   64'd447614171,
      64'd223810500,   64'd111905677,   64'd55952892,    64'd27976453,
      64'd13988227,    64'd6994114,     64'd3497057,     64'd1748528,
      64'd874264,      64'd437132,      64'd218566,      64'd109283,
      64'd54642,       64'd27321,       64'd13660,       64'd6830
   };

   // rotation angle of one cordic step in degrees with frac fraction bits
   function automatic logic [63:0] atan_step(input int idx, input int frac);
      return (ATAN_NANODEG[idx] << frac) / NANODEG_PER_DEG;
   endfunction

   // cycles from the operand inputs of the cordic unit to its angle register
   function automatic int cordic_latency(input int frac);
      return frac + 3;
   endfunction

endpackage

// ----- rtl/tilt_angle_alarm.sv -----
// tilt_angle_alarm: top level of the accelerometer tilt alarm, roll and pitch cordic
// pipes, folding, threshold compare and configuration registers. Depends on tilt_pkg
// and tilt_cordic.
//
//  channel   ports                                   transfer when
//  -------   -------------------------------------   ----------------------
//  request   start, busy, req_accel_x/y/z            start high, busy low
//  response  rsp_valid, rsp_roll_deg, rsp_pitch_deg,  rsp_valid high, 1 cycle
//            rsp_danger, rsp_warning
//  config    csr_wr_en, csr_index, csr_wdata         csr_wr_en high
//
// One sample enters every cycle; busy is always low. Each result passes through one
// pipeline stage per cordic step plus operand, rounding, quadrant and compare stages.
// Synchronous reset clears the valid bits and loads the threshold defaults.
// The receiver cannot stall, so the pipeline advances every cycle.

module tilt_angle_alarm
   import tilt_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [ACCEL_W-1:0] req_accel_x,
   input  logic signed [ACCEL_W-1:0] req_accel_y,
   input  logic signed [ACCEL_W-1:0] req_accel_z,
   output logic                      rsp_valid,
   output logic [ROLL_W-1:0]         rsp_roll_deg,
   output logic [PITCH_W-1:0]        rsp_pitch_deg,
   output logic                      rsp_danger,
   output logic                      rsp_warning,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CORDIC_LAT = cordic_latency(ANGLE_FRAC_BITS);
   localparam logic signed [ANGLE_W-1:0]     ROLL_HALF_TURN = ANGLE_W'(HALF_TURN);
   localparam logic signed [PITCH_EXT_W-1:0] P_OFFSET  = PITCH_EXT_W'(PITCH_OFFSET);
   localparam logic signed [PITCH_EXT_W-1:0] P_LIMIT   = PITCH_EXT_W'(PITCH_FOLD_LIMIT);
   localparam logic signed [PITCH_EXT_W-1:0] P_FULL    = PITCH_EXT_W'(FULL_TURN);

   // threshold registers
   logic [ROLL_W-1:0]  roll_danger_ff;
   logic [PITCH_W-1:0] pitch_danger_ff;
   logic [ROLL_W-1:0]  roll_warning_ff;
   logic [PITCH_W-1:0] pitch_warning_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_danger_ff   <= ROLL_DANGER_RST;
         pitch_danger_ff  <= PITCH_DANGER_RST;
         roll_warning_ff  <= ROLL_WARNING_RST;
         pitch_warning_ff <= PITCH_WARNING_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROLL_DANGER:   roll_danger_ff   <= csr_wdata[ROLL_W-1:0];
            CSR_PITCH_DANGER:  pitch_danger_ff  <= csr_wdata[PITCH_W-1:0];
            CSR_ROLL_WARNING:  roll_warning_ff  <= csr_wdata[ROLL_W-1:0];
            CSR_PITCH_WARNING: pitch_warning_ff <= csr_wdata[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   // valid bits travel alongside the cordic pipes
   logic vld_ff [0:CORDIC_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CORDIC_LAT; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start && !busy;
         for (int j = 1; j < CORDIC_LAT; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   assign busy = 1'b0;

   // roll and pitch angle pipes
   logic signed [ANGLE_W-1:0] roll_ang;
   logic signed [ANGLE_W-1:0] pitch_ang;

   tilt_cordic #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
      .clock (clock),
      .num   (req_accel_x),
      .den   (req_accel_z),
      .angle (roll_ang)
   );

   tilt_cordic #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
      .clock (clock),
      .num   (req_accel_y),
      .den   (req_accel_z),
      .angle (pitch_ang)
   );

   // fold the angles and compare with the thresholds
   logic signed [ANGLE_W-1:0]     roll_fold;
   logic signed [PITCH_EXT_W-1:0] pitch_off;
   logic signed [PITCH_EXT_W-1:0] pitch_lim;
   logic signed [PITCH_EXT_W-1:0] pitch_fold;
   logic [ROLL_W-1:0]             roll_deg_in;
   logic [PITCH_W-1:0]            pitch_deg_in;
   logic                          danger_in;
   logic                          warning_in;

   always_comb begin
      if (!roll_ang[ANGLE_W-1] && (roll_ang != '0)) begin
         roll_fold = ROLL_HALF_TURN - roll_ang;
      end else if (roll_ang[ANGLE_W-1]) begin
         roll_fold = roll_ang + ROLL_HALF_TURN;
      end else begin
         roll_fold = '0;
      end

      pitch_off  = PITCH_EXT_W'(pitch_ang) + P_OFFSET;
      pitch_lim  = (pitch_off > P_LIMIT) ? (P_FULL - pitch_off) : pitch_off;
      pitch_fold = pitch_lim[PITCH_EXT_W-1] ? (PITCH_EXT_W'(0) - pitch_lim) : pitch_lim;

      roll_deg_in  = roll_fold[ROLL_W-1:0];
      pitch_deg_in = pitch_fold[PITCH_W-1:0];
      danger_in    = (roll_deg_in >= roll_danger_ff) || (pitch_deg_in >= pitch_danger_ff);
      warning_in   = !danger_in &&
                     ((roll_deg_in >= roll_warning_ff) || (pitch_deg_in >= pitch_warning_ff));
   end

   // result register
   logic               rsp_valid_ff;
   logic [ROLL_W-1:0]  rsp_roll_ff;
   logic [PITCH_W-1:0] rsp_pitch_ff;
   logic               rsp_danger_ff;
   logic               rsp_warning_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[CORDIC_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_roll_ff    <= roll_deg_in;
      rsp_pitch_ff   <= pitch_deg_in;
      rsp_danger_ff  <= danger_in;
      rsp_warning_ff <= warning_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_roll_deg  = rsp_roll_ff;
   assign rsp_pitch_deg = rsp_pitch_ff;
   assign rsp_danger    = rsp_danger_ff;
   assign rsp_warning   = rsp_warning_ff;

endmodule

// ----- rtl/tilt_cordic.sv -----
// tilt_cordic: pipelined vectoring cordic atan2 in whole degrees, one sample per cycle.
// Depends on tilt_pkg.

module tilt_cordic
   import tilt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic signed [ACCEL_W-1:0] num,
   input  logic signed [ACCEL_W-1:0] den,
   output logic signed [ANGLE_W-1:0] angle
);

   localparam int N_ITER = FRAC_BITS;
   localparam int MAG_W  = ACCEL_W + 1;
   localparam int DW     = MAG_W + PRE_SHIFT + 3;
   localparam int ZW     = FRAC_BITS + 9;
   localparam logic signed [ZW-1:0] Z_LIMIT = ZW'(longint'(RIGHT_ANGLE) << FRAC_BITS);
   localparam logic signed [ZW-1:0] Z_HALF  = ZW'(longint'(1) << (FRAC_BITS - 1));
   localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_TURN = ANGLE_W'(HALF_TURN);

   logic signed [DW-1:0] x_ff [0:N_ITER];
   logic signed [DW-1:0] y_ff [0:N_ITER];
   logic signed [ZW-1:0] z_ff [0:N_ITER];
   quad_type             quad_ff [0:N_ITER + 1];

   logic [MAG_W-1:0] num_mag;
   logic [MAG_W-1:0] den_mag;
   quad_type         quad_in;

   // operand magnitudes and quadrant flags
   always_comb begin
      num_mag = num[ACCEL_W-1] ? (MAG_W'(0) - MAG_W'(num)) : MAG_W'(num);
      den_mag = den[ACCEL_W-1] ? (MAG_W'(0) - MAG_W'(den)) : MAG_W'(den);
      quad_in.num_neg  = num[ACCEL_W-1];
      quad_in.den_neg  = den[ACCEL_W-1];
      quad_in.num_zero = (num == '0);
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= {{(DW-MAG_W-PRE_SHIFT){1'b0}}, den_mag, {PRE_SHIFT{1'b0}}};
      y_ff[0]    <= {{(DW-MAG_W-PRE_SHIFT){1'b0}}, num_mag, {PRE_SHIFT{1'b0}}};
      z_ff[0]    <= '0;
      quad_ff[0] <= quad_in;
   end

   // one rotation per stage, driving y toward zero
   for (genvar k = 0; k < N_ITER; k++) begin : g_iter
      localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(k, FRAC_BITS));
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [DW-1:0] x_in;
      logic signed [DW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      always_comb begin
         dx = y_ff[k] >>> k;
         dy = x_ff[k] >>> k;
         if (!y_ff[k][DW-1] && (y_ff[k] != '0)) begin
            x_in = x_ff[k] + dx;
            y_in = y_ff[k] - dy;
            z_in = z_ff[k] + STEP;
         end else begin
            x_in = x_ff[k] - dx;
            y_in = y_ff[k] + dy;
            z_in = z_ff[k] - STEP;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[k+1]    <= x_in;
         y_ff[k+1]    <= y_in;
         z_ff[k+1]    <= z_in;
         quad_ff[k+1] <= quad_ff[k];
      end
   end

   // clamp to the first quadrant and round to whole degrees
   logic signed [ZW-1:0] z_clamp;
   logic signed [ZW-1:0] z_round;
   logic [ROUND_W-1:0]   t_in;
   logic [ROUND_W-1:0]   t_ff;

   always_comb begin
      if (z_ff[N_ITER][ZW-1]) begin
         z_clamp = '0;
      end else if (z_ff[N_ITER] > Z_LIMIT) begin
         z_clamp = Z_LIMIT;
      end else begin
         z_clamp = z_ff[N_ITER];
      end
      z_round = z_clamp + Z_HALF;
      t_in    = quad_ff[N_ITER].num_zero ? '0 : z_round[FRAC_BITS +: ROUND_W];
   end

   always_ff @(posedge clock) begin
      t_ff              <= t_in;
      quad_ff[N_ITER+1] <= quad_ff[N_ITER];
   end

   // restore the quadrant
   logic signed [ANGLE_W-1:0] t_ext;
   logic signed [ANGLE_W-1:0] ang_half;
   logic signed [ANGLE_W-1:0] angle_in;
   logic signed [ANGLE_W-1:0] angle_ff;

   always_comb begin
      t_ext    = ANGLE_W'(t_ff);
      ang_half = quad_ff[N_ITER+1].den_neg ? (ANGLE_HALF_TURN - t_ext) : t_ext;
      angle_in = quad_ff[N_ITER+1].num_neg ? (ANGLE_W'(0) - ang_half) : ang_half;
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

// ----- rtl/tilt_chk.sv -----
// tilt_chk: port-level checks of the tilt angle alarm and the bind that attaches them.
// Depends on tilt_pkg and tilt_angle_alarm.

module tilt_chk
   import tilt_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [ROLL_W-1:0]         rsp_roll_deg,
   input logic [PITCH_W-1:0]        rsp_pitch_deg,
   input logic                      rsp_danger,
   input logic                      rsp_warning
);

   localparam int LAT = cordic_latency(ANGLE_FRAC_BITS) + 1;

   // every accepted sample gives a result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted sample produced no result");

   // no result without a sample accepted at the matching cycle
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching accepted sample");

   // danger and warning are exclusive
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_danger && rsp_warning))
      else $error("danger and warning both set");

   // folded angles stay in range
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_deg <= ROLL_W'(HALF_TURN)) &&
                    (rsp_pitch_deg <= PITCH_W'(PITCH_FOLD_LIMIT)))
      else $error("folded angle out of range");

endmodule

bind tilt_angle_alarm tilt_chk #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_tilt_chk (.*);

// ----- bench/tilt_angle_alarm_tb.sv -----
`timescale 1ns / 100ps
// tilt_angle_alarm_tb: self-checking bench for the tilt angle alarm, with a command-style
// driver, a result monitor and a cordic angle predictor. Depends on tilt_pkg and tilt_angle_alarm.

module tilt_angle_alarm_tb;
   import tilt_pkg::*;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int PIPE_LATENCY    = ANGLE_FRAC_BITS + 4;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] x;
      logic signed [ACCEL_W-1:0] y;
      logic signed [ACCEL_W-1:0] z;
   } accel_type;

   typedef struct {
      accel_type          accel;
      logic [ROLL_W-1:0]  roll;
      logic [PITCH_W-1:0] pitch;
      logic               danger;
      logic               warning;
   } tilt_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [ACCEL_W-1:0] req_accel_x = '0;
   logic signed [ACCEL_W-1:0] req_accel_y = '0;
   logic signed [ACCEL_W-1:0] req_accel_z = '0;
   logic                      rsp_valid;
   logic [ROLL_W-1:0]         rsp_roll_deg;
   logic [PITCH_W-1:0]        rsp_pitch_deg;
   logic                      rsp_danger;
   logic                      rsp_warning;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_ROLL_DANGER;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // threshold copies kept by the bench
   logic [ROLL_W-1:0]  thr_roll_danger;
   logic [PITCH_W-1:0] thr_pitch_danger;
   logic [ROLL_W-1:0]  thr_roll_warning;
   logic [PITCH_W-1:0] thr_pitch_warning;

   accel_type pending_accel [$];
   tilt_type  tilt_expected [$];
   int        in_flight   = 0;
   int        gap_left    = 0;
   int        mismatches  = 0;
   int        cycle_count = 0;
   bit        gaps_on     = 1'b1;

   tilt_angle_alarm #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_accel_x   (req_accel_x),
      .req_accel_y   (req_accel_y),
      .req_accel_z   (req_accel_z),
      .rsp_valid     (rsp_valid),
      .rsp_roll_deg  (rsp_roll_deg),
      .rsp_pitch_deg (rsp_pitch_deg),
      .rsp_danger    (rsp_danger),
      .rsp_warning   (rsp_warning),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // vectoring cordic on magnitudes, whole degrees 0..90
   function automatic int quadrant_angle_deg(input longint num_mag, input longint den_mag);
      longint xr, yr, zr, dx, dy, step, zmax;
      xr   = den_mag <<< PRE_SHIFT;
      yr   = num_mag <<< PRE_SHIFT;
      zr   = 0;
      zmax = longint'(RIGHT_ANGLE) <<< ANGLE_FRAC_BITS;
      if (num_mag == 0)
         return 0;
      for (int i = 0; i < ANGLE_FRAC_BITS && i < ATAN_TABLE_LEN; i++) begin
         step = longint'((ATAN_NANODEG[i] << ANGLE_FRAC_BITS) / NANODEG_PER_DEG);
         dx   = yr >>> i;
         dy   = xr >>> i;
         if (yr > 0) begin
            xr = xr + dx;
            yr = yr - dy;
            zr = zr + step;
         end else begin
            xr = xr - dx;
            yr = yr + dy;
            zr = zr - step;
         end
      end
      if (zr < 0)
         zr = 0;
      if (zr > zmax)
         zr = zmax;
      return int'((zr + (longint'(1) <<< (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS);
   endfunction

   // rounded four-quadrant angle, -180..180
   function automatic int signed_angle_deg(input longint num, input longint den);
      int ang;
      ang = quadrant_angle_deg(num < 0 ? -num : num, den < 0 ? -den : den);
      if (den < 0)
         ang = HALF_TURN - ang;
      if (num < 0)
         ang = -ang;
      return ang;
   endfunction

   // folded angles and alarm flags of one sample under the current thresholds
   function automatic tilt_type tilt_of_accel(input accel_type a);
      tilt_type t;
      int       roll, pitch;
      roll  = signed_angle_deg(a.x, a.z);
      pitch = signed_angle_deg(a.y, a.z) + PITCH_OFFSET;
      if (roll > 0)
         roll = HALF_TURN - roll;
      else if (roll < 0)
         roll = roll + HALF_TURN;
      if (pitch > PITCH_FOLD_LIMIT)
         pitch = FULL_TURN - pitch;
      if (pitch < 0)
         pitch = -pitch;
      t.accel   = a;
      t.roll    = ROLL_W'(roll);
      t.pitch   = PITCH_W'(pitch);
      t.danger  = (roll >= int'(thr_roll_danger)) || (pitch >= int'(thr_pitch_danger));
      t.warning = !t.danger &&
                  ((roll >= int'(thr_roll_warning)) || (pitch >= int'(thr_pitch_warning)));
      return t;
   endfunction

   // one line per mismatch, every mismatch is counted
   task automatic flag_mismatch(input string what, input accel_type a, input int got,
                                input int want);
      $display("mismatch %s: got %0d want %0d (x=%0d y=%0d z=%0d)",
               what, got, want, a.x, a.y, a.z);
      mismatches++;
   endtask

   // one axis value: full range, small, moderate, zero or extreme
   function automatic logic signed [ACCEL_W-1:0] random_axis();
      case ($urandom_range(0, 5))
         0, 1:    return ACCEL_W'($urandom);
         2:       return ACCEL_W'(int'($urandom_range(0, 400)) - 200);
         3:       return '0;
         4: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7fff;
               1:       return 16'sh8000;
               2:       return 16'sh0001;
               default: return 16'shffff;
            endcase
         end
         default: return ACCEL_W'(int'($urandom_range(0, 16000)) - 8000);
      endcase
   endfunction

   // mostly tilt-like samples with gravity on z, the rest per-axis random
   function automatic accel_type random_accel();
      accel_type a;
      int        g;
      if ($urandom_range(0, 9) < 6) begin
         g   = int'($urandom_range(12000, 20000));
         a.z = ACCEL_W'($urandom_range(0, 1) ? -g : g);
         a.x = ACCEL_W'(int'($urandom_range(0, 12000)) - 6000);
         a.y = ACCEL_W'(int'($urandom_range(0, 12000)) - 6000);
      end else begin
         a.x = random_axis();
         a.y = random_axis();
         a.z = random_axis();
      end
      return a;
   endfunction

   // idle cycles after a transfer: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (!gaps_on)
         return 0;
      r = int'($urandom_range(0, 99));
      if (r < 55)
         return 0;
      if (r < 85)
         return int'($urandom_range(1, 3));
      if (r < 97)
         return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   task automatic push_accel(input int x, input int y, input int z);
      accel_type a;
      a.x = ACCEL_W'(x);
      a.y = ACCEL_W'(y);
      a.z = ACCEL_W'(z);
      pending_accel.push_back(a);
   endtask

   // hold until every queued sample has been checked
   task automatic wait_idle();
      while (pending_accel.size() != 0 || in_flight != 0)
         @(posedge clock);
   endtask

   task automatic load_thresholds(input logic [CSR_DATA_W-1:0] roll_dng,
                                  input logic [CSR_DATA_W-1:0] pitch_dng,
                                  input logic [CSR_DATA_W-1:0] roll_wrn,
                                  input logic [CSR_DATA_W-1:0] pitch_wrn);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ROLL_DANGER;
      csr_wdata <= roll_dng;
      @(posedge clock);
      csr_index <= CSR_PITCH_DANGER;
      csr_wdata <= pitch_dng;
      @(posedge clock);
      csr_index <= CSR_ROLL_WARNING;
      csr_wdata <= roll_wrn;
      @(posedge clock);
      csr_index <= CSR_PITCH_WARNING;
      csr_wdata <= pitch_wrn;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count)
         pending_accel.push_back(random_accel());
      wait_idle();
   endtask

   // threshold registers as the block holds them
   always @(posedge clock) begin
      if (reset) begin
         thr_roll_danger   <= ROLL_DANGER_RST;
         thr_pitch_danger  <= PITCH_DANGER_RST;
         thr_roll_warning  <= ROLL_WARNING_RST;
         thr_pitch_warning <= PITCH_WARNING_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROLL_DANGER:   thr_roll_danger   <= csr_wdata[ROLL_W-1:0];
            CSR_PITCH_DANGER:  thr_pitch_danger  <= csr_wdata[PITCH_W-1:0];
            CSR_ROLL_WARNING:  thr_roll_warning  <= csr_wdata[ROLL_W-1:0];
            CSR_PITCH_WARNING: thr_pitch_warning <= csr_wdata[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   // driver: record the transfer, then load the next sample or idle
   always @(posedge clock) begin
      accel_type a;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            a.x = req_accel_x;
            a.y = req_accel_y;
            a.z = req_accel_z;
            tilt_expected.push_back(tilt_of_accel(a));
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               // noise on the data ports while start is low
               start       <= 1'b0;
               gap_left    <= gap_left - 1;
               req_accel_x <= ACCEL_W'($urandom);
               req_accel_y <= ACCEL_W'($urandom);
               req_accel_z <= ACCEL_W'($urandom);
            end else if (pending_accel.size() != 0) begin
               a = pending_accel.pop_front();
               in_flight++;
               req_accel_x <= a.x;
               req_accel_y <= a.y;
               req_accel_z <= a.z;
               start       <= 1'b1;
               gap_left    <= pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      tilt_type want;
      if (!reset && rsp_valid) begin
         if (tilt_expected.size() == 0) begin
            want.accel = '0;
            flag_mismatch("unexpected result, roll_deg", want.accel, rsp_roll_deg, 0);
         end else begin
            want = tilt_expected.pop_front();
            in_flight--;
            if (rsp_roll_deg !== want.roll)
               flag_mismatch("roll_deg", want.accel, rsp_roll_deg, want.roll);
            if (rsp_pitch_deg !== want.pitch)
               flag_mismatch("pitch_deg", want.accel, rsp_pitch_deg, want.pitch);
            if (rsp_danger !== want.danger)
               flag_mismatch("danger", want.accel, rsp_danger, want.danger);
            if (rsp_warning !== want.warning)
               flag_mismatch("warning", want.accel, rsp_warning, want.warning);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tilt_angle_alarm_tb NOT OK");
         $finish;
      end
   end

   // stimulus phases
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples under the reset thresholds
      gaps_on = 1'b1;
      push_accel(0, 0, 0);                  // both operands zero
      push_accel(0, 0, 1000);               // zero numerator, positive denominator
      push_accel(0, 0, -1000);              // zero numerator, negative denominator
      push_accel(0, 0, -32768);
      push_accel(32767, 32767, 32767);
      push_accel(-32768, -32768, -32768);
      push_accel(32767, -32768, 0);         // zero denominator
      push_accel(-32768, 32767, 0);
      push_accel(1, -1, 0);
      push_accel(-1, 1, -32768);
      push_accel(1, 1, 32767);
      push_accel(0, 1000, -1000);           // pitch past the fold limit
      push_accel(0, -2000, -32000);         // pitch negative after offset
      push_accel(5000, 0, -16354);          // roll warning only
      push_accel(10000, 0, -16000);         // roll danger
      push_accel(0, 3000, -16000);          // pitch warning only
      push_accel(-5000, 0, 16384);
      push_accel(16384, 16384, -16384);
      push_accel(-1, -1, -1);
      push_accel(21845, -21846, 21845);
      push_accel(-21846, 21845, -21846);
      push_accel(-32768, 0, 1);
      wait_idle();

      // zero thresholds always fire danger
      load_thresholds(9'd0, 9'd0, 9'd0, 9'd0);
      gaps_on = 1'b0;
      run_random(60);

      // top of the stated range
      load_thresholds(9'd180, 9'd300, 9'd180, 9'd300);
      gaps_on = 1'b1;
      run_random(120);

      // all ones, roll registers keep the low byte
      load_thresholds(9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff);
      run_random(60);

      // wide warning band
      load_thresholds(9'd150, 9'd250, 9'd40, 9'd60);
      gaps_on = 1'b0;
      run_random(120);

      // random settings inside the range
      repeat (3) begin
         load_thresholds(9'($urandom_range(0, 180)), 9'($urandom_range(0, 300)),
                         9'($urandom_range(0, 180)), 9'($urandom_range(0, 300)));
         gaps_on = !gaps_on;
         run_random(100);
      end

      // back to the reset values
      load_thresholds(9'(ROLL_DANGER_RST), 9'(PITCH_DANGER_RST),
                      9'(ROLL_WARNING_RST), 9'(PITCH_WARNING_RST));
      gaps_on = 1'b1;
      run_random(150);

      wait_idle();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (tilt_expected.size() != 0)
         flag_mismatch("results missing, count", tilt_expected[0].accel,
                       tilt_expected.size(), 0);
      if (mismatches == 0)
         $display("tilt_angle_alarm_tb OK");
      else
         $display("tilt_angle_alarm_tb NOT OK");
      $finish;
   end

endmodule
